[rtl/core/skt_pkg.sv]
// Package with the field widths, codes and entry type of the sorted keyed table.
`default_nettype none
package skt_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 16;
  localparam int PRICE_W  = 24;
  localparam int STOCK_W  = 16;
  localparam int INDEX_W  = 7;
  localparam int STATUS_W = 2;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RAISE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  // Largest price; a raise saturates here.
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  // Divide by ten as multiply by ceil(2^27 / 10) and shift; exact for 24-bit prices.
  localparam logic [PRICE_W-1:0] DIV10_MUL   = 24'hCCCCCD;
  localparam int                 DIV10_SHIFT = 27;

  // One stored table entry.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [STOCK_W-1:0] stock;
  } entry_t;

endpackage
`default_nettype wire

[rtl/core/skt_if.sv]
// Valid/ready channel interfaces for the table commands and their results.
`default_nettype none
interface skt_req_if;
  import skt_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   key;
  logic [PRICE_W-1:0] price;
  logic [STOCK_W-1:0] stock;
  logic [INDEX_W-1:0] index;

  modport source (output valid, cmd, key, price, stock, index, input ready);
  modport sink (input valid, cmd, key, price, stock, index, output ready);
endinterface

interface skt_rsp_if;
  import skt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    result_key;
  logic [PRICE_W-1:0]  result_price;
  logic [STOCK_W-1:0]  result_stock;

  modport source (output valid, status, result_key, result_price, result_stock, input ready);
  modport sink (input valid, status, result_key, result_price, result_stock, output ready);
endinterface
`default_nettype wire

[rtl/core/sorted_keyed_table.sv]
// Sorted keyed table: entries kept in ascending key order in one memory, with
// insert, read by position, raise price and query stock, all walked by a small sequencer.
// The block takes one command beat at a time and is not ready until its result is in the
// output register. Every memory access goes through one read and one write port, one entry
// per cycle, so the time per command is set by how far the sequencer has to walk: a read
// fetches one entry, an insert moves each entry with a key not below the new one up one
// place, a query walks up from the first entry to the position where the key is found or
// the search stops, and a raise walks the same way and then takes two more steps, the
// multiply-by-reciprocal for the tenth and the saturating add. A full-table insert, a read
// past the count, or a raise or query on an empty table goes straight to its result. Each
// command also waits while an earlier result sits untaken in the output register.
// The result register lets the next command be accepted while a result still waits to be
// taken. Entries are not cleared at reset; only the entry count is.
`default_nettype none
module sorted_keyed_table
  import skt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  skt_req_if.sink   req,
  skt_rsp_if.source rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_RD,
    S_LOOK,
    S_MUL,
    S_ADD,
    S_EMIT
  } state_t;

  state_t             state;
  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [PRICE_W-1:0] price_r;
  logic [STOCK_W-1:0] stock_r;
  logic [PRICE_W-1:0] quot;
  logic [CW-1:0]      count;
  logic [CW-1:0]      ptr;

  // Result waiting to go out, and the output register itself.
  logic [STATUS_W-1:0] res_status;
  logic [KEY_W-1:0]    res_key;
  logic [PRICE_W-1:0]  res_price;
  logic [STOCK_W-1:0]  res_stock;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_key;
  logic [PRICE_W-1:0]  out_price;
  logic [STOCK_W-1:0]  out_stock;

  // Entry memory with one write and one registered read port.
  entry_t          mem [DEPTH];
  entry_t          rd_data;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  logic                 accept;
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        ptr_m2;
  logic [CW-1:0]        ptr_p1;
  logic [IW-1:0]        idx_ext;
  logic [IW-1:0]        idx_m1;
  logic [IW-1:0]        cnt_ext;
  logic                 idx_bad;
  logic                 shift_up;
  logic [2*PRICE_W-1:0] prod;
  logic [PRICE_W:0]     sum;
  logic [PRICE_W-1:0]   new_price;
  logic                 out_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_key   = out_key;
  assign rsp.result_price = out_price;
  assign rsp.result_stock = out_stock;

  // Address arithmetic and the position check for reads.
  assign cnt_m1  = count - CW'(1);
  assign ptr_m2  = ptr - CW'(2);
  assign ptr_p1  = ptr + CW'(1);
  assign idx_ext = (req.index == '0) ? IW'(1) : IW'(req.index);
  assign idx_m1  = idx_ext - IW'(1);
  assign cnt_ext = IW'(count);
  assign idx_bad = idx_ext > cnt_ext;

  // An entry moves up while its key is not below the new key.
  assign shift_up = (ptr != '0) && (rd_data.key >= key_r);

  // Arithmetic for the raise: tenth by reciprocal, then saturating add.
  assign prod      = price_r * DIV10_MUL;
  assign sum       = {1'b0, price_r} + {1'b0, quot};
  assign new_price = sum[PRICE_W] ? PRICE_MAX : sum[PRICE_W-1:0];

  // Memory read address and write port, chosen by the sequencer.
  always_comb begin
    rd_addr = ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr[AW-1:0];
    wr_data = '{key: key_r, price: price_r, stock: stock_r};
    unique case (state)
      S_IDLE: begin
        if (req.cmd == CMD_INSERT) begin
          rd_addr = cnt_m1[AW-1:0];
        end else if (req.cmd == CMD_READ) begin
          rd_addr = idx_m1[AW-1:0];
        end else begin
          rd_addr = '0;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (shift_up) begin
          wr_data = rd_data;
          rd_addr = ptr_m2[AW-1:0];
        end
      end
      S_LOOK: begin
        rd_addr = ptr_p1[AW-1:0];
      end
      S_ADD: begin
        wr_en   = 1'b1;
        wr_data = '{key: key_r, price: new_price, stock: stock_r};
      end
      S_RD, S_MUL, S_EMIT: begin
        rd_addr = ptr[AW-1:0];
      end
      default: begin
        rd_addr = ptr[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // Sequencer, entry count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The beat is taken; a new one loaded in S_EMIT takes its place instead.
      if (out_valid && rsp.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r      <= req.cmd;
            key_r      <= req.key;
            price_r    <= req.price;
            stock_r    <= req.stock;
            res_key    <= '0;
            res_price  <= '0;
            res_stock  <= '0;
            unique case (req.cmd)
              CMD_INSERT: begin
                if (count == CW'(DEPTH)) begin
                  res_status <= ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  res_status <= ST_OK;
                  ptr        <= count;
                  state      <= S_INS_CMP;
                end
              end
              CMD_READ: begin
                if (idx_bad) begin
                  res_status <= ST_RANGE;
                  state      <= S_EMIT;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_RD;
                end
              end
              CMD_RAISE, CMD_QUERY: begin
                ptr <= '0;
                if (count == '0) begin
                  res_status <= ST_NOT_FOUND;
                  state      <= S_EMIT;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_LOOK;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_IDLE;
              end
            endcase
          end
        end
        S_INS_CMP: begin
          // Move one entry up, or drop the new entry into the hole.
          if (shift_up) begin
            ptr <= ptr - CW'(1);
          end else begin
            count <= count + CW'(1);
            state <= S_EMIT;
          end
        end
        S_RD: begin
          res_key   <= rd_data.key;
          res_price <= rd_data.price;
          res_stock <= rd_data.stock;
          state     <= S_EMIT;
        end
        S_LOOK: begin
          // Walk up from the first entry until the key is reached or passed.
          if (rd_data.key < key_r) begin
            if (ptr_p1 >= count) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_EMIT;
            end else begin
              ptr <= ptr_p1;
            end
          end else if (rd_data.key == key_r) begin
            if (cmd_r == CMD_QUERY) begin
              res_key   <= key_r;
              res_stock <= rd_data.stock;
              state     <= S_EMIT;
            end else begin
              price_r <= rd_data.price;
              stock_r <= rd_data.stock;
              state   <= S_MUL;
            end
          end else begin
            res_status <= ST_NOT_FOUND;
            state      <= S_EMIT;
          end
        end
        S_MUL: begin
          quot  <= PRICE_W'(prod >> DIV10_SHIFT);
          state <= S_ADD;
        end
        S_ADD: begin
          res_key   <= key_r;
          res_price <= new_price;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_key    <= res_key;
            out_price  <= res_price;
            out_stock  <= res_stock;
            state      <= S_IDLE;
          end else if (out_valid && rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/skt_checker.sv]
// Port-level checks for the sorted keyed table, bound to its top level.
`default_nettype none
module skt_checker
  import skt_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [STATUS_W-1:0] rsp_status,
  input wire logic [KEY_W-1:0]    rsp_key,
  input wire logic [PRICE_W-1:0]  rsp_price,
  input wire logic [STOCK_W-1:0]  rsp_stock
);

  // No result beat is offered right after reset.
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A stalled result beat keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_key)
      && $stable(rsp_price) && $stable(rsp_stock))
    else $error("stalled result beat changed");

  // One command at a time: after a command beat the block is busy.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted back to back");

  // Any failure status carries zero data fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_key == '0 && rsp_price == '0 && rsp_stock == '0)
    else $error("failed result carries data");

endmodule

bind sorted_keyed_table skt_checker u_skt_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_key    (rsp.result_key),
  .rsp_price  (rsp.result_price),
  .rsp_stock  (rsp.result_stock)
);
`default_nettype wire

[tb/sorted_keyed_table_tb.sv]
// Self-checking testbench for the sorted keyed table: directed and random commands with scoring.
module sorted_keyed_table_tb;
  import skt_pkg::*;

  localparam int TABLE_DEPTH      = 64;
  localparam int RANDOM_PER_PHASE = 385;
  localparam int HOLD_CYCLES      = 300;
  localparam int QUIET_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 100;
  localparam int REPORT_LIMIT     = 10;

  // One result beat as the table returns it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [PRICE_W-1:0]  price;
    logic [STOCK_W-1:0]  stock;
  } table_result_t;

  // Shadow copy of the table that works out the result of every accepted command
  // and scores the result beats against it in order.
  class table_checker;
    entry_t        rows[TABLE_DEPTH];
    int unsigned   fill;
    table_result_t expected_results[$];
    int unsigned   errors;
    int unsigned   status_seen[4];

    function new();
      fill   = 0;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Position of the first entry whose key is not below k, or the fill level.
    function int unsigned first_not_below(logic [KEY_W-1:0] k);
      int unsigned pos;
      pos = 0;
      while (pos < fill && rows[pos].key < k) pos++;
      return pos;
    endfunction

    function void note_command(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                               logic [PRICE_W-1:0] p, logic [STOCK_W-1:0] s,
                               logic [INDEX_W-1:0] idx);
      table_result_t res;
      int unsigned   pos;
      int unsigned   pick;
      logic [PRICE_W:0] grown;
      res = '0;
      res.status = ST_OK;
      case (c)
        CMD_INSERT: begin
          if (fill >= TABLE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            // New entry goes ahead of any entries with an equal key.
            pos = first_not_below(k);
            for (int unsigned i = fill; i > pos; i--) rows[i] = rows[i-1];
            rows[pos].key   = k;
            rows[pos].price = p;
            rows[pos].stock = s;
            fill++;
          end
        end
        CMD_READ: begin
          pick = (idx == '0) ? 32'd1 : 32'(idx);
          if (pick > fill) begin
            res.status = ST_RANGE;
          end else begin
            res.key   = rows[pick-1].key;
            res.price = rows[pick-1].price;
            res.stock = rows[pick-1].stock;
          end
        end
        default: begin
          pos = first_not_below(k);
          if (pos >= fill || rows[pos].key != k) begin
            res.status = ST_NOT_FOUND;
          end else if (c == CMD_RAISE) begin
            // Add a truncated tenth and clamp at the largest price.
            grown = (PRICE_W+1)'({1'b0, rows[pos].price} + rows[pos].price / 10);
            if (grown > {1'b0, PRICE_MAX}) grown = {1'b0, PRICE_MAX};
            rows[pos].price = grown[PRICE_W-1:0];
            res.key   = k;
            res.price = grown[PRICE_W-1:0];
          end else begin
            res.key   = k;
            res.stock = rows[pos].stock;
          end
        end
      endcase
      expected_results.push_back(res);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      status_seen[got.status]++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Unexpected result beat: status %0d key %h price %h stock %h",
                   got.status, got.key, got.price, got.stock);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.key !== want.key ||
          got.price !== want.price || got.stock !== want.stock) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("Mismatch: expected status %0d key %h price %h stock %h",
                   want.status, want.key, want.price, want.stock);
          $display("          actual   status %0d key %h price %h stock %h",
                   got.status, got.key, got.price, got.stock);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  skt_req_if req_ch ();
  skt_rsp_if rsp_ch ();

  sorted_keyed_table #(
    .DEPTH (TABLE_DEPTH)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  table_checker     sb;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  bit               hold_request   = 1'b0;
  int unsigned      hold_left      = 0;
  int unsigned      quiet_cycles   = 0;
  int unsigned      cmds_sent[4]   = '{0, 0, 0, 0};
  logic [KEY_W-1:0] used_keys[$];

  // Clock.
  always #5 clk = ~clk;

  // Score result beats first, then note the command beat taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result('{rsp_ch.status, rsp_ch.result_key, rsp_ch.result_price,
                          rsp_ch.result_stock});
      if (req_ch.valid && req_ch.ready)
        sb.note_command(req_ch.cmd, req_ch.key, req_ch.price, req_ch.stock, req_ch.index);
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("sorted_keyed_table test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one command beat, with random idle cycles ahead of it, and wait until taken.
  task automatic send_command(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                              logic [PRICE_W-1:0] p, logic [STOCK_W-1:0] s,
                              logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= c;
    req_ch.key   <= k;
    req_ch.price <= p;
    req_ch.stock <= s;
    req_ch.index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    cmds_sent[c]++;
  endtask

  // Random command; raises and queries mostly take keys already in the table so that they hit, the rest are noise.
  task automatic random_command();
    int               r;
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    logic [PRICE_W-1:0] p;
    logic [STOCK_W-1:0] s;
    logic [INDEX_W-1:0] idx;
    r   = $urandom_range(99);
    k   = KEY_W'($urandom);
    p   = PRICE_W'($urandom);
    s   = STOCK_W'($urandom);
    idx = INDEX_W'($urandom_range(TABLE_DEPTH));
    if (r < 8) begin
      c = CMD_INSERT;
      if (used_keys.size() != 0 && $urandom_range(3) == 0)
        k = used_keys[$urandom_range(used_keys.size() - 1)];
      else if ($urandom_range(9) == 0)
        k = '0;
      else if ($urandom_range(9) == 0)
        k = '1;
      if ($urandom_range(3) == 0) p = PRICE_MAX - PRICE_W'($urandom_range(20'hFFFFF));
      if (used_keys.size() < TABLE_DEPTH) used_keys.push_back(k);
    end else if (r < 38) begin
      c = CMD_READ;
      if ($urandom_range(3) != 0)
        idx = INDEX_W'($urandom_range(used_keys.size() < TABLE_DEPTH ? used_keys.size() + 1
                                                                     : TABLE_DEPTH));
    end else begin
      c = (r < 63) ? CMD_RAISE : CMD_QUERY;
      if (used_keys.size() != 0 && $urandom_range(4) != 0)
        k = used_keys[$urandom_range(used_keys.size() - 1)];
    end
    send_command(c, k, p, s, idx);
  endtask

  // Main sequence.
  initial begin
    sb = new();
    req_ch.valid = 1'b0;
    req_ch.cmd   = CMD_READ;
    req_ch.key   = '0;
    req_ch.price = '0;
    req_ch.stock = '0;
    req_ch.index = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, key and price extremes, duplicates, index edges, saturation.
    send_command(CMD_READ,   16'h0000, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_QUERY,  16'h0000, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_RAISE,  16'hFFFF, 24'hFFFFFF, 16'hFFFF, 7'd64);
    send_command(CMD_INSERT, 16'h8000, 24'd1000,   16'd5,    7'd0);
    send_command(CMD_INSERT, 16'h0000, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_INSERT, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 7'd127);
    send_command(CMD_INSERT, 16'h8000, 24'hF00000, 16'd1,    7'd0);
    send_command(CMD_READ,   16'h0000, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_READ,   16'h0000, 24'h000000, 16'h0000, 7'd1);
    send_command(CMD_READ,   16'h0000, 24'h000000, 16'h0000, 7'd4);
    send_command(CMD_READ,   16'h0000, 24'h000000, 16'h0000, 7'd5);
    send_command(CMD_READ,   16'hFFFF, 24'hFFFFFF, 16'hFFFF, 7'd64);
    send_command(CMD_RAISE,  16'h8000, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_RAISE,  16'hFFFF, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_RAISE,  16'h0000, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_RAISE,  16'h1234, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_QUERY,  16'h8000, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_QUERY,  16'hFFFF, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_QUERY,  16'h7FFF, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_RAISE,  16'h8000, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_INSERT, 16'h7FFF, 24'd9,      16'hAAAA, 7'd0);
    send_command(CMD_RAISE,  16'h7FFF, 24'h000000, 16'h0000, 7'd0);
    send_command(CMD_READ,   16'h0000, 24'h000000, 16'h0000, 7'd2);
    used_keys.push_back(16'h8000);
    used_keys.push_back(16'h0000);
    used_keys.push_back(16'hFFFF);
    used_keys.push_back(16'h8000);
    used_keys.push_back(16'h7FFF);

    // Random phases with different idle patterns; the first one also holds off results.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_request   = 1'b1;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
        end
      endcase
      repeat (RANDOM_PER_PHASE) random_command();
    end
    req_ch.valid <= 1'b0;

    // Drain the outstanding results, then give stray beats a chance to show up.
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d inserts, %0d reads, %0d raises and %0d queries; table holds %0d.",
             cmds_sent[CMD_INSERT], cmds_sent[CMD_READ], cmds_sent[CMD_RAISE],
             cmds_sent[CMD_QUERY], sb.fill);
    $display("Results: %0d ok, %0d not found, %0d full, %0d out of range; %0d errors.",
             sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL],
             sb.status_seen[ST_RANGE], sb.errors);
    if (sb.errors == 0)
      $display("sorted_keyed_table test passed");
    else
      $display("sorted_keyed_table test failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/skt_pkg.sv
rtl/core/skt_if.sv
rtl/core/sorted_keyed_table.sv
rtl/core/skt_checker.sv
tb/sorted_keyed_table_tb.sv
